@@ rtl/core/bloom_filter_three_hash_defines.svh @@
// ----------------------------------------------------------------------------
// Bloom filter assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BLOOM_FILTER_THREE_HASH_DEFINES_SVH
`define BLOOM_FILTER_THREE_HASH_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property outside reset.
`define BFT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bloom filter check failed");
// Check a property that also holds across reset.
`define BFT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bloom filter check failed");
`else
`define BFT_ASSERT(lbl, prop)
`define BFT_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ rtl/core/bft_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bloom filter package
// Shared types, codes and hash constants for the controller and datapath.
// ----------------------------------------------------------------------------
package bft_pkg;

  localparam int unsigned CfgWidth = 14;

  localparam logic [31:0] SeedA    = 32'h811c9dc5;
  localparam logic [31:0] SeedB    = 32'ha3a3a3a3;
  localparam logic [31:0] SeedC    = 32'h12345678;
  localparam logic [31:0] FnvPrime = 32'd16777619;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_LOAD  = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_PRB_RD,
    ST_PRB_UPD,
    ST_QRESP
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_start;
    logic clr_step;
    logic load_wr;
    logic rd_issue;
    logic key_step;
    logic div_step;
    logic probe_rd;
    logic probe_upd;
    logic resp_read;
    logic resp_query;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_done;
    logic n_zero;
    logic div_done;
    logic probe_last;
    logic is_query;
    logic out_busy;
  } status_t;

endpackage

@@ rtl/core/bloom_filter_three_hash.sv @@
`timescale 1ns / 1ps
// One beat in flight at a time. Key byte without last, and load: taken in ST_IDLE.
// Read: ST_READ, held by any output stall. With bits_in_use 0: add ends, query responds.
// Last key byte otherwise: modulo (one remainder bit per cycle in three lanes), then
// three probes (read then update per hash), then a response for a query.
// Reset and every bits_in_use write sweep the store clear, one byte per cycle
// ((MAX_BITS+7)/8 bytes, 1024 by default) while no beat is accepted.
// ----------------------------------------------------------------------------
// Bloom filter, three FNV-1a hashes
// Top level joining the controller and datapath to the stream ports.
// ----------------------------------------------------------------------------
`include "bloom_filter_three_hash_defines.svh"

module bloom_filter_three_hash #(
  parameter int unsigned MAX_BITS = 8192
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [13:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // data_byte[7:0], byte_valid[8], byte_index[18:9]
  input  logic [1:0]  s_tuser,   // kind
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // might_contain[0], filter_byte[8:1]
  output logic        m_tuser    // answer_kind
);

  bft_pkg::cmd_t    cmd;
  bft_pkg::status_t status;
  logic             out_hit;
  logic [7:0]       out_byte;

  assign cfg_ready = 1'b1;

  bft_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_kind   (s_tuser),
    .in_last   (s_tlast),
    .cfg_valid (cfg_valid),
    .status    (status),
    .in_ready  (s_tready),
    .cmd       (cmd)
  );

  bft_dp #(
    .MAX_BITS (MAX_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .in_kind       (s_tuser),
    .in_byte       (s_tdata[7:0]),
    .in_byte_valid (s_tdata[8]),
    .in_last       (s_tlast),
    .in_index      (s_tdata[18:9]),
    .out_ready     (m_tready),
    .out_valid     (m_tvalid),
    .out_kind      (m_tuser),
    .out_hit       (out_hit),
    .out_byte      (out_byte)
  );

  assign m_tdata = {7'h00, out_byte, out_hit};

  // Reset starts the clearing sweep, so no beat is taken right after it
  `BFT_ASSERT_ALWAYS(a_rst_blocks_input, rst |=> !s_tready)
  // A register write clears the store before the next beat
  `BFT_ASSERT(a_cfg_blocks_input, cfg_valid |=> !s_tready)
  // Readouts carry no membership flag, answers carry no store byte
  `BFT_ASSERT(a_read_no_hit, (m_tvalid && m_tuser) |-> !m_tdata[0])
  `BFT_ASSERT(a_answer_no_byte, (m_tvalid && !m_tuser) |-> (m_tdata[8:1] == 8'h00))

endmodule

@@ rtl/core/bft_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bloom filter controller
// Sequences store clearing, key hashing, modulo, probes and responses.
// ----------------------------------------------------------------------------
module bft_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        in_kind,
  input  logic              in_last,
  input  logic              cfg_valid,
  input  bft_pkg::status_t  status,
  output logic              in_ready,
  output bft_pkg::cmd_t     cmd
);

  bft_pkg::state_t state;
  bft_pkg::state_t state_next;
  bft_pkg::kind_t  kind;
  logic            accept;

  assign kind   = bft_pkg::kind_t'(in_kind);
  assign accept = in_valid && in_ready;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bft_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Decide next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      bft_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_done) begin
          state_next = bft_pkg::ST_IDLE;
        end
      end
      bft_pkg::ST_IDLE: begin
        // Hold off the input while a register write lands
        in_ready = !cfg_valid;
        if (accept) begin
          unique case (kind)
            bft_pkg::KIND_LOAD: begin
              cmd.load_wr = 1'b1;
            end
            bft_pkg::KIND_READ: begin
              cmd.rd_issue = 1'b1;
              state_next   = bft_pkg::ST_READ;
            end
            default: begin
              cmd.key_step = 1'b1;
              if (in_last) begin
                if (!status.n_zero) begin
                  state_next = bft_pkg::ST_DIV;
                end else if (kind == bft_pkg::KIND_QUERY) begin
                  state_next = bft_pkg::ST_QRESP;
                end
              end
            end
          endcase
        end
      end
      bft_pkg::ST_READ: begin
        if (!status.out_busy) begin
          cmd.resp_read = 1'b1;
          state_next    = bft_pkg::ST_IDLE;
        end
      end
      bft_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = bft_pkg::ST_PRB_RD;
        end
      end
      bft_pkg::ST_PRB_RD: begin
        cmd.probe_rd = 1'b1;
        state_next   = bft_pkg::ST_PRB_UPD;
      end
      bft_pkg::ST_PRB_UPD: begin
        cmd.probe_upd = 1'b1;
        if (!status.probe_last) begin
          state_next = bft_pkg::ST_PRB_RD;
        end else if (status.is_query) begin
          state_next = bft_pkg::ST_QRESP;
        end else begin
          state_next = bft_pkg::ST_IDLE;
        end
      end
      bft_pkg::ST_QRESP: begin
        if (!status.out_busy) begin
          cmd.resp_query = 1'b1;
          state_next     = bft_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bft_pkg::ST_CLEAR;
      end
    endcase
    // A register write restarts the clearing sweep
    if (cfg_valid) begin
      cmd.clr_start = 1'b1;
      state_next    = bft_pkg::ST_CLEAR;
    end
  end

endmodule

@@ rtl/core/bft_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bloom filter datapath
// Hash lanes, bit-serial modulo, bit store memory and output register.
// ----------------------------------------------------------------------------
module bft_dp #(
  parameter int unsigned MAX_BITS = 8192
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bft_pkg::cmd_t                 cmd,
  output bft_pkg::status_t              status,
  input  logic                          cfg_valid,
  input  logic [bft_pkg::CfgWidth-1:0]  cfg_data,
  input  logic [1:0]                    in_kind,
  input  logic [7:0]                    in_byte,
  input  logic                          in_byte_valid,
  input  logic                          in_last,
  input  logic [9:0]                    in_index,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_kind,
  output logic                          out_hit,
  output logic [7:0]                    out_byte
);

  localparam int unsigned StoreBytes = (MAX_BITS + 7) / 8;
  localparam int unsigned AW  = (StoreBytes > 1) ? $clog2(StoreBytes) : 1;
  localparam int unsigned IW  = (AW > 10) ? AW : 10;
  localparam int unsigned PW  = (AW > 11) ? AW : 11;
  localparam int unsigned NW  = bft_pkg::CfgWidth;

  logic [NW-1:0]   bits_in_use;
  logic [NW-1:0]   n_eff;
  logic [31:0]     hash [3];
  logic [31:0]     hash_fold [3];
  logic [31:0]     div_h [3];
  logic [NW-1:0]   rem [3];
  logic [NW-1:0]   rem_next [3];
  logic [4:0]      div_cnt;
  logic [1:0]      probe_idx;
  logic            hit;
  logic            is_query;
  logic [AW-1:0]   clr_addr;
  logic [7:0]      rd_mask;
  logic [7:0]      mem [StoreBytes];
  logic [7:0]      mem_rdata;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [7:0]      mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  logic [IW-1:0]   in_index_w;
  logic [AW-1:0]   in_addr;
  logic            in_range;
  logic [7:0]      in_mask;
  logic [NW-1:0]   probe_pos;
  logic [PW-1:0]   probe_byte_w;
  logic [AW-1:0]   probe_addr;
  logic [7:0]      probe_bit;

  // Mask of live filter bits within one store byte
  function automatic logic [7:0] live_mask(input logic [9:0] idx, input logic [NW-1:0] n);
    logic [NW-1:0] base;
    logic [NW-1:0] cnt;
    base = NW'({idx, 3'b000});
    cnt  = n - base;
    if (base >= n) begin
      return 8'h00;
    end else if (cnt >= NW'(8)) begin
      return 8'hFF;
    end else begin
      return ~(8'hFF << cnt[2:0]);
    end
  endfunction

  // Clamp the configured size to the store
  assign n_eff = (32'(bits_in_use) > MAX_BITS) ? NW'(MAX_BITS) : bits_in_use;

  assign in_index_w = IW'(in_index);
  assign in_addr    = in_index_w[AW-1:0];
  assign in_range   = 32'(in_index) < StoreBytes;
  assign in_mask    = live_mask(in_index, n_eff);

  assign probe_pos    = rem[probe_idx];
  assign probe_byte_w = PW'(probe_pos[NW-1:3]);
  assign probe_addr   = probe_byte_w[AW-1:0];
  assign probe_bit    = 8'h01 << probe_pos[2:0];

  // Fold the current key byte into each hash lane
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hash_fold[i] = in_byte_valid ? (hash[i] ^ {24'h0, in_byte}) * bft_pkg::FnvPrime
                                   : hash[i];
    end
  end

  // One restoring division step per lane
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [NW:0] r2;
      r2 = {rem[i], div_h[i][31]};
      if (r2 >= {1'b0, n_eff}) begin
        r2 = r2 - {1'b0, n_eff};
      end
      rem_next[i] = r2[NW-1:0];
    end
  end

  // Hold the size register
  always_ff @(posedge clk) begin
    if (rst) begin
      bits_in_use <= '0;
    end else if (cfg_valid) begin
      bits_in_use <= cfg_data;
    end
  end

  // Advance the running hashes, reseed at end of key
  always_ff @(posedge clk) begin
    if (rst) begin
      hash[0] <= bft_pkg::SeedA;
      hash[1] <= bft_pkg::SeedB;
      hash[2] <= bft_pkg::SeedC;
    end else if (cmd.key_step) begin
      if (in_last) begin
        hash[0] <= bft_pkg::SeedA;
        hash[1] <= bft_pkg::SeedB;
        hash[2] <= bft_pkg::SeedC;
      end else begin
        hash <= hash_fold;
      end
    end
  end

  // Load the divider at end of key, shift one bit a step
  always_ff @(posedge clk) begin
    if (cmd.key_step && in_last) begin
      div_h    <= hash_fold;
      rem      <= '{default: '0};
      div_cnt  <= '0;
      is_query <= (bft_pkg::kind_t'(in_kind) == bft_pkg::KIND_QUERY);
    end else if (cmd.div_step) begin
      for (int i = 0; i < 3; i++) begin
        div_h[i] <= div_h[i] << 1;
      end
      rem     <= rem_next;
      div_cnt <= div_cnt + 5'd1;
    end
  end

  // Step through the three probes and gather the hit flag
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_idx <= '0;
      hit       <= 1'b1;
    end else if (cmd.key_step && in_last) begin
      probe_idx <= '0;
      hit       <= 1'b1;
    end else if (cmd.probe_upd) begin
      probe_idx <= probe_idx + 2'd1;
      hit       <= hit & |(mem_rdata & probe_bit);
    end
  end

  // Sweep the clear address
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Select the memory write and read port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = 8'h00;
    if (cmd.clr_step) begin
      mem_we = 1'b1;
    end else if (cmd.load_wr) begin
      mem_we    = in_range;
      mem_waddr = in_addr;
      mem_wdata = in_byte & in_mask;
    end else if (cmd.probe_upd) begin
      mem_we    = !is_query;
      mem_waddr = probe_addr;
      mem_wdata = mem_rdata | probe_bit;
    end
    mem_re    = cmd.rd_issue || cmd.probe_rd;
    mem_raddr = cmd.rd_issue ? in_addr : probe_addr;
  end

  // Bit store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  // Keep the live mask of a pending readout
  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_mask <= in_range ? in_mask : 8'h00;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.resp_read || cmd.resp_query) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp_read) begin
      out_kind <= 1'b1;
      out_hit  <= 1'b0;
      out_byte <= mem_rdata & rd_mask;
    end else if (cmd.resp_query) begin
      out_kind <= 1'b0;
      out_hit  <= hit;
      out_byte <= 8'h00;
    end
  end

  assign status.clr_done   = (clr_addr == AW'(StoreBytes - 1));
  assign status.n_zero     = (n_eff == '0);
  assign status.div_done   = (div_cnt == 5'd31);
  assign status.probe_last = (probe_idx == 2'd2);
  assign status.is_query   = is_query;
  assign status.out_busy   = out_valid && !out_ready;

endmodule
